// ===== src/assert_macros.svh =====
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, muted while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== src/cpt_pkg.sv =====
// Shared widths, gains, sine table builder and saturation helper for the Clarke/Park block.
package cpt_pkg;

    // Sample and angle widths
    localparam int SAMPLE_WIDTH     = 16;
    localparam int ANGLE_WIDTH      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    // Quarter-wave sine table, Q15, entries 0..DEPTH inclusive
    localparam int SINE_W   = 15;
    localparam int TRIG_W   = SINE_W + 1;
    localparam int ROM_AW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PHASE_W  = ANGLE_WIDTH - 2;
    localparam int TAYLOR_TERMS = 14;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Clarke gains, Q16
    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = 18;
    localparam logic [GAIN_W-1:0] K_SQRT_1_6  = 18'd26755;
    localparam logic [GAIN_W-1:0] K_INV_SQRT2 = 18'd46341;
    localparam logic [GAIN_W-1:0] K_INV_SQRT3 = 18'd37837;

    // Datapath widths
    localparam int CLK_SUM_W   = SAMPLE_WIDTH + 2;
    localparam int CLK_PROD_W  = CLK_SUM_W + GAIN_W;
    localparam int CLK_W       = CLK_PROD_W - GAIN_FRAC;
    localparam int PARK_FRAC   = 15;
    localparam int PARK_PROD_W = CLK_W + TRIG_W;
    localparam int PARK_W      = PARK_PROD_W + 1 - PARK_FRAC;
    localparam int SAT_W       = PARK_W;

    // Saturation bounds at the wide width
    localparam logic signed [SAT_W-1:0] SAT_MAX =
        {{(SAT_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN =
        {{(SAT_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] val;
        logic                           clip;
    } sat_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] alpha;
        logic signed [SAMPLE_WIDTH-1:0] beta;
        logic signed [SAMPLE_WIDTH-1:0] zero_seq;
        logic signed [SAMPLE_WIDTH-1:0] direct;
        logic signed [SAMPLE_WIDTH-1:0] quadrature;
        logic                           saturated;
    } res_t;

    // Build the quarter-wave table from a truncated Q30 Taylor series
    function automatic sine_rom_t build_sine();
        sine_rom_t         tbl;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] acc;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            acc  = '0;
            for (int k = 0; k < TAYLOR_TERMS; k++) begin
                if (k[0]) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
                term = (term * x2) >> 30;
                term = term / 64'((2 * k + 2) * (2 * k + 3));
            end
            if (acc < 0) begin
                acc = '0;
            end
            acc = (acc + 64'sd16384) >>> 15;
            if (acc > 64'sd32767) begin
                acc = 64'sd32767;
            end
            tbl[i] = acc[SINE_W-1:0];
        end
        return tbl;
    endfunction

    // Clamp a wide value to the sample range and flag the clip
    function automatic sat_t saturate(input logic signed [SAT_W-1:0] v);
        sat_t r;
        if (v > SAT_MAX) begin
            r.val  = SAT_MAX[SAMPLE_WIDTH-1:0];
            r.clip = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val  = SAT_MIN[SAMPLE_WIDTH-1:0];
            r.clip = 1'b1;
        end else begin
            r.val  = v[SAMPLE_WIDTH-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/clarke_park_transform.sv =====
// Top level of the power-invariant Clarke/Park transform.
// Beats pass Clarke and sine stages, Park stages, then the output register to m_*.
// Throughput: one beat per cycle while s_ready; five pipeline stages, two-entry output skid.
// The sine table is a dual-read constant ROM, one read per port per enabled cycle.
// Reset (aresetn, synchronous, active low) empties the pipeline and the output skid.
module clarke_park_transform (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  s_phase_a,
    input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  s_phase_b,
    input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  s_phase_c,
    input  logic [cpt_pkg::ANGLE_WIDTH-1:0]          s_angle,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_alpha,
    output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_beta,
    output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_zero_seq,
    output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_direct,
    output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_quadrature,
    output logic                                     m_saturated
);

    localparam int SW = cpt_pkg::SAT_W;

    logic en;
    logic [4:0] valid_reg;
    logic signed [cpt_pkg::CLK_W-1:0]  cl_alpha, cl_beta, cl_zero;
    logic signed [cpt_pkg::CLK_W-1:0]  pk_alpha, pk_beta, pk_zero;
    logic signed [cpt_pkg::TRIG_W-1:0] sin_val, cos_val;
    logic signed [cpt_pkg::PARK_W-1:0] pk_direct, pk_quad;
    cpt_pkg::sat_t sat_al, sat_be, sat_z, sat_d, sat_q;
    cpt_pkg::res_t res_new;
    cpt_pkg::res_t out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;
    logic          push;

    // Advance the pipeline whenever the skid entry is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Carry valid bits alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], s_valid};
        end
    end

    cpt_clarke u_clarke (
        .aclk     (aclk),
        .en       (en),
        .phase_a  (s_phase_a),
        .phase_b  (s_phase_b),
        .phase_c  (s_phase_c),
        .alpha    (cl_alpha),
        .beta     (cl_beta),
        .zero_seq (cl_zero)
    );

    cpt_sine_rom u_sine_rom (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_angle),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    cpt_park u_park (
        .aclk       (aclk),
        .en         (en),
        .alpha_in   (cl_alpha),
        .beta_in    (cl_beta),
        .zero_in    (cl_zero),
        .sin_val    (sin_val),
        .cos_val    (cos_val),
        .alpha_out  (pk_alpha),
        .beta_out   (pk_beta),
        .zero_out   (pk_zero),
        .direct     (pk_direct),
        .quadrature (pk_quad)
    );

    // Clamp every result to the sample range
    assign sat_al = cpt_pkg::saturate(SW'(pk_alpha));
    assign sat_be = cpt_pkg::saturate(SW'(pk_beta));
    assign sat_z  = cpt_pkg::saturate(SW'(pk_zero));
    assign sat_d  = cpt_pkg::saturate(pk_direct);
    assign sat_q  = cpt_pkg::saturate(pk_quad);

    always_comb begin
        res_new.alpha      = sat_al.val;
        res_new.beta       = sat_be.val;
        res_new.zero_seq   = sat_z.val;
        res_new.direct     = sat_d.val;
        res_new.quadrature = sat_q.val;
        res_new.saturated  = sat_al.clip | sat_be.clip | sat_z.clip | sat_d.clip | sat_q.clip;
    end

    assign push = valid_reg[4] && en;

    // Output register with a skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move payload alongside the valid flags
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= res_new;
            end
        end else if (push) begin
            skid_reg <= res_new;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_alpha      = out_reg.alpha;
    assign m_beta       = out_reg.beta;
    assign m_zero_seq   = out_reg.zero_seq;
    assign m_direct     = out_reg.direct;
    assign m_quadrature = out_reg.quadrature;
    assign m_saturated  = out_reg.saturated;

endmodule

// ===== src/cpt_clarke.sv =====
// Three-stage Clarke transform: phase sums, gain products, rounding.
module cpt_clarke (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] phase_a,
    input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] phase_b,
    input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] phase_c,
    output logic signed [cpt_pkg::CLK_W-1:0]        alpha,
    output logic signed [cpt_pkg::CLK_W-1:0]        beta,
    output logic signed [cpt_pkg::CLK_W-1:0]        zero_seq
);

    localparam int SW = cpt_pkg::CLK_SUM_W;
    localparam int PW = cpt_pkg::CLK_PROD_W;
    localparam int FR = cpt_pkg::GAIN_FRAC;

    localparam logic signed [PW-1:0] K_AL = PW'(cpt_pkg::K_SQRT_1_6);
    localparam logic signed [PW-1:0] K_BE = PW'(cpt_pkg::K_INV_SQRT2);
    localparam logic signed [PW-1:0] K_Z  = PW'(cpt_pkg::K_INV_SQRT3);
    localparam logic signed [PW-1:0] RND  = PW'(1) <<< (FR - 1);

    logic signed [SW-1:0] sum_al_reg, sum_be_reg, sum_z_reg;
    logic signed [PW-1:0] prod_al_reg, prod_be_reg, prod_z_reg;
    logic signed [PW-1:0] rnd_al, rnd_be, rnd_z;
    logic signed [cpt_pkg::CLK_W-1:0] al_reg, be_reg, z_reg;

    // Form the phase combinations
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_al_reg <= (SW'(phase_a) <<< 1) - SW'(phase_b) - SW'(phase_c);
            sum_be_reg <= SW'(phase_b) - SW'(phase_c);
            sum_z_reg  <= SW'(phase_a) + SW'(phase_b) + SW'(phase_c);
        end
    end

    // Scale by the Q16 gains
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_al_reg <= PW'(sum_al_reg) * K_AL;
            prod_be_reg <= PW'(sum_be_reg) * K_BE;
            prod_z_reg  <= PW'(sum_z_reg) * K_Z;
        end
    end

    // Round half up and drop the fraction
    assign rnd_al = prod_al_reg + RND;
    assign rnd_be = prod_be_reg + RND;
    assign rnd_z  = prod_z_reg + RND;

    always_ff @(posedge aclk) begin
        if (en) begin
            al_reg <= rnd_al[PW-1:FR];
            be_reg <= rnd_be[PW-1:FR];
            z_reg  <= rnd_z[PW-1:FR];
        end
    end

    assign alpha    = al_reg;
    assign beta     = be_reg;
    assign zero_seq = z_reg;

endmodule

// ===== src/cpt_sine_rom.sv =====
// Three-stage sine and cosine lookup from the quarter-wave table.
module cpt_sine_rom (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [cpt_pkg::ANGLE_WIDTH-1:0]      angle,
    output logic signed [cpt_pkg::TRIG_W-1:0]    sin_val,
    output logic signed [cpt_pkg::TRIG_W-1:0]    cos_val
);

    localparam int AW    = cpt_pkg::ROM_AW;
    localparam int PH_W  = cpt_pkg::PHASE_W;
    localparam int MW    = PH_W + AW;
    localparam int TW    = cpt_pkg::TRIG_W;
    localparam logic [AW-1:0] DEPTH = AW'(cpt_pkg::SINE_TABLE_DEPTH);

    localparam cpt_pkg::sine_rom_t SINE_ROM = cpt_pkg::build_sine();

    logic [1:0]    quad;
    logic [MW-1:0] scaled;
    logic [AW-1:0] idx;
    logic [AW-1:0] sin_addr_reg, cos_addr_reg;
    logic          sin_neg_reg, cos_neg_reg;
    logic [cpt_pkg::SINE_W-1:0] sin_rom_reg, cos_rom_reg;
    logic          sin_neg2_reg, cos_neg2_reg;
    logic signed [TW-1:0] sin_reg, cos_reg;

    // Map the in-quadrant phase onto the table index
    assign quad   = angle[cpt_pkg::ANGLE_WIDTH-1:PH_W];
    assign scaled = MW'(angle[PH_W-1:0]) * MW'(DEPTH);
    assign idx    = scaled[MW-1:PH_W];

    // Mirror odd quadrants; cosine sits one quadrant ahead
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_addr_reg <= quad[0] ? (DEPTH - idx) : idx;
            cos_addr_reg <= quad[0] ? idx : (DEPTH - idx);
            sin_neg_reg  <= quad[1];
            cos_neg_reg  <= quad[1] ^ quad[0];
        end
    end

    // Read both ports of the table
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_rom_reg  <= SINE_ROM[sin_addr_reg];
            cos_rom_reg  <= SINE_ROM[cos_addr_reg];
            sin_neg2_reg <= sin_neg_reg;
            cos_neg2_reg <= cos_neg_reg;
        end
    end

    // Apply the quadrant sign
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_neg2_reg ? -$signed({1'b0, sin_rom_reg})
                                    :  $signed({1'b0, sin_rom_reg});
            cos_reg <= cos_neg2_reg ? -$signed({1'b0, cos_rom_reg})
                                    :  $signed({1'b0, cos_rom_reg});
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== src/cpt_park.sv =====
// Two-stage Park rotation: four products, then rounded sum and difference.
module cpt_park (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [cpt_pkg::CLK_W-1:0]     alpha_in,
    input  logic signed [cpt_pkg::CLK_W-1:0]     beta_in,
    input  logic signed [cpt_pkg::CLK_W-1:0]     zero_in,
    input  logic signed [cpt_pkg::TRIG_W-1:0]    sin_val,
    input  logic signed [cpt_pkg::TRIG_W-1:0]    cos_val,
    output logic signed [cpt_pkg::CLK_W-1:0]     alpha_out,
    output logic signed [cpt_pkg::CLK_W-1:0]     beta_out,
    output logic signed [cpt_pkg::CLK_W-1:0]     zero_out,
    output logic signed [cpt_pkg::PARK_W-1:0]    direct,
    output logic signed [cpt_pkg::PARK_W-1:0]    quadrature
);

    localparam int PP = cpt_pkg::PARK_PROD_W;
    localparam int SW = PP + 1;
    localparam int FR = cpt_pkg::PARK_FRAC;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (FR - 1);

    logic signed [PP-1:0] p_ca_reg, p_sb_reg, p_cb_reg, p_sa_reg;
    logic signed [cpt_pkg::CLK_W-1:0] al_d1_reg, be_d1_reg, z_d1_reg;
    logic signed [cpt_pkg::CLK_W-1:0] al_d2_reg, be_d2_reg, z_d2_reg;
    logic signed [SW-1:0] sum_d, sum_q;
    logic signed [cpt_pkg::PARK_W-1:0] d_reg, q_reg;

    // Form the rotation products
    always_ff @(posedge aclk) begin
        if (en) begin
            p_ca_reg  <= PP'(cos_val) * PP'(alpha_in);
            p_sb_reg  <= PP'(sin_val) * PP'(beta_in);
            p_cb_reg  <= PP'(cos_val) * PP'(beta_in);
            p_sa_reg  <= PP'(sin_val) * PP'(alpha_in);
            al_d1_reg <= alpha_in;
            be_d1_reg <= beta_in;
            z_d1_reg  <= zero_in;
        end
    end

    // Combine, round half up and drop the Q15 fraction
    assign sum_d = SW'(p_ca_reg) + SW'(p_sb_reg) + RND;
    assign sum_q = SW'(p_cb_reg) - SW'(p_sa_reg) + RND;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg     <= sum_d[SW-1:FR];
            q_reg     <= sum_q[SW-1:FR];
            al_d2_reg <= al_d1_reg;
            be_d2_reg <= be_d1_reg;
            z_d2_reg  <= z_d1_reg;
        end
    end

    assign alpha_out  = al_d2_reg;
    assign beta_out   = be_d2_reg;
    assign zero_out   = z_d2_reg;
    assign direct     = d_reg;
    assign quadrature = q_reg;

endmodule

// ===== src/cpt_checker.sv =====
// Port-level checker for the Clarke/Park block and its bind.
`include "assert_macros.svh"

module cpt_checker (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     s_ready,
    input logic                                     m_valid,
    input logic                                     m_ready,
    input logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_alpha,
    input logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_beta,
    input logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_zero_seq,
    input logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_direct,
    input logic signed [cpt_pkg::SAMPLE_WIDTH-1:0]  m_quadrature,
    input logic                                     m_saturated
);

    localparam int W = cpt_pkg::SAMPLE_WIDTH;
    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W - 1){1'b0}}};

    logic at_rail;
    logic [5*W:0] m_payload;

    // Some output sits on a rail
    assign at_rail = (m_alpha == S_MAX) || (m_alpha == S_MIN) ||
                     (m_beta == S_MAX) || (m_beta == S_MIN) ||
                     (m_zero_seq == S_MAX) || (m_zero_seq == S_MIN) ||
                     (m_direct == S_MAX) || (m_direct == S_MIN) ||
                     (m_quadrature == S_MAX) || (m_quadrature == S_MIN);

    // Gather the whole result beat
    assign m_payload = {m_alpha, m_beta, m_zero_seq, m_direct, m_quadrature, m_saturated};

    // Result beat holds while stalled
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_payload))
    // Input backpressure only once a result is waiting
    `ASSERT_IMPLIES(a_ready_cause, aclk, aresetn, !s_ready, m_valid)
    // A clip flag means some value was pinned to a rail
    `ASSERT_IMPLIES(a_sat_rail, aclk, aresetn, m_valid && m_saturated, at_rail)
    // Input is taken again once the waiting result drains
    `ASSERT_NEXT(a_ready_back, aclk, aresetn, !s_ready && m_ready, s_ready)

endmodule

bind clarke_park_transform cpt_checker u_cpt_checker (.*);
